// ===== sv/cgs_pkg.sv =====
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types and constants for the color gradient sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cgs_pkg;

   localparam int MAX_STOPS_DEF = 16;

   localparam int POS_W   = 17;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 4 * CHAN_W;
   localparam int ENTRY_W = POS_W + COLOR_W;

   // blend numerator: 255 * 65536 fits in 24 bits
   localparam int NUM_W  = 24;
   localparam int PROD_W = CHAN_W + POS_W;
   localparam int QSTEPS = CHAN_W;

   localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_ENDS = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_END_RD,
      ST_END_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_INSERT,
      ST_SHIFT_WR,
      ST_BLEND_GO,
      ST_BLEND_WAIT,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      BL_IDLE,
      BL_MUL_A,
      BL_MUL_B,
      BL_DIV
   } blend_state_type;

   typedef struct packed {
      logic [CHAN_W-1:0] lo_chan;
      logic [CHAN_W-1:0] hi_chan;
      logic [POS_W-1:0]  n;
      logic [POS_W-1:0]  d;
   } blend_req_type;

endpackage

`default_nettype wire

// ===== sv/cgs_if.sv =====
// ----------------------------------------------------------------------------
// cgs_if
// Valid/ready channels for gradient requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface cgs_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [cgs_pkg::POS_W-1:0]  position;
   logic [cgs_pkg::CHAN_W-1:0] in_red;
   logic [cgs_pkg::CHAN_W-1:0] in_green;
   logic [cgs_pkg::CHAN_W-1:0] in_blue;
   logic [cgs_pkg::CHAN_W-1:0] in_alpha;

   modport source (output valid, mode, position, in_red, in_green, in_blue, in_alpha,
                   input ready);
   modport sink   (input valid, mode, position, in_red, in_green, in_blue, in_alpha,
                   output ready);
endinterface

interface cgs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cgs_pkg::CHAN_W-1:0] out_red;
   logic [cgs_pkg::CHAN_W-1:0] out_green;
   logic [cgs_pkg::CHAN_W-1:0] out_blue;
   logic [cgs_pkg::CHAN_W-1:0] out_alpha;
   logic [1:0]                 status;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, status,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, status,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/color_gradient_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// color_gradient_sampler_unit
// Multi-stop linear RGBA gradient: stop table writes and gradient samples.
// req_ch: mode 0 writes a stop (insert in position order or recolor an
// existing one), mode 1 samples the gradient. rsp_ch: one response per
// request, color plus status (ok, missing end stops, table full).
// One request at a time; req_ch.ready is high only while idle. A request
// scans the stop table one stop at a time from the bottom, reading each
// stop from the registered read port before checking it:
//   write:  scan, then recolor or insert; inserting in front of an existing
//           stop first shifts each stop above it up by one slot
//   sample: end-stop check, scan, then a blend of each of the four channels
//           in turn in the one blend unit; missing end stops end it sooner
// The response sits in an output register; the next request is taken while
// it waits, but a finished request holds until rsp_ch.ready frees the slot.
// Reset empties the table at once (stop count cleared, no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module color_gradient_sampler_unit #(
   parameter int MAX_STOPS = cgs_pkg::MAX_STOPS_DEF
) (
   input logic        clock,
   input logic        reset,
   cgs_req_if.sink    req_ch,
   cgs_rsp_if.source  rsp_ch
);

   localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CNT_W  = $clog2(MAX_STOPS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STOPS);

   cgs_pkg::seq_state_type state_ff, state_in;
   logic                          mode_ff, mode_in;
   logic [cgs_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [cgs_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              top_ff, top_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [cgs_pkg::POS_W-1:0]     lo_pos_ff, lo_pos_in;
   logic [cgs_pkg::COLOR_W-1:0]   lo_color_ff, lo_color_in;
   logic [cgs_pkg::POS_W-1:0]     hi_pos_ff, hi_pos_in;
   logic [cgs_pkg::COLOR_W-1:0]   hi_color_ff, hi_color_in;
   logic [1:0]                    chan_ff, chan_in;
   logic [cgs_pkg::COLOR_W-1:0]   res_color_ff, res_color_in;
   cgs_pkg::status_type           res_status_ff, res_status_in;
   logic                          rsp_valid_ff;
   logic [cgs_pkg::COLOR_W-1:0]   rsp_color_ff;
   cgs_pkg::status_type           rsp_status_ff;

   logic                          req_ready;
   logic                          load_rsp;
   logic [cgs_pkg::POS_W-1:0]     req_pos_sat;
   logic [CNT_W-1:0]              last_idx;
   logic [CNT_W-1:0]              top_m1;

   logic                          mem_wr_en;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic [cgs_pkg::ENTRY_W-1:0]   mem_wr_data;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic [cgs_pkg::ENTRY_W-1:0]   mem_rd_data;
   logic [cgs_pkg::POS_W-1:0]     rd_pos;
   logic [cgs_pkg::COLOR_W-1:0]   rd_color;

   logic                          blend_start;
   cgs_pkg::blend_req_type        blend_req;
   logic                          blend_done;
   logic [cgs_pkg::CHAN_W-1:0]    blend_q;

   cgs_stop_mem #(
      .DEPTH  (MAX_STOPS),
      .ADDR_W (ADDR_W),
      .DATA_W (cgs_pkg::ENTRY_W)
   ) u_stop_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   cgs_blend_unit u_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .req   (blend_req),
      .done  (blend_done),
      .quot  (blend_q)
   );

   assign rd_pos   = mem_rd_data[cgs_pkg::ENTRY_W-1:cgs_pkg::COLOR_W];
   assign rd_color = mem_rd_data[cgs_pkg::COLOR_W-1:0];
   assign last_idx = count_ff - CNT_W'(1);
   assign top_m1   = top_ff - CNT_W'(1);

   assign req_pos_sat = (req_ch.position > cgs_pkg::POS_ONE) ? cgs_pkg::POS_ONE
                                                             : req_ch.position;

   assign blend_req.lo_chan = lo_color_ff[{chan_ff, 3'b000} +: cgs_pkg::CHAN_W];
   assign blend_req.hi_chan = hi_color_ff[{chan_ff, 3'b000} +: cgs_pkg::CHAN_W];
   assign blend_req.n       = pos_ff - lo_pos_ff;
   assign blend_req.d       = hi_pos_ff - lo_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgs_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      color_ff      <= color_in;
      idx_ff        <= idx_in;
      top_ff        <= top_in;
      lo_pos_ff     <= lo_pos_in;
      lo_color_ff   <= lo_color_in;
      hi_pos_ff     <= hi_pos_in;
      hi_color_ff   <= hi_color_in;
      chan_ff       <= chan_in;
      res_color_ff  <= res_color_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      color_in      = color_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      count_in      = count_ff;
      lo_pos_in     = lo_pos_ff;
      lo_color_in   = lo_color_ff;
      hi_pos_in     = hi_pos_ff;
      hi_color_in   = hi_color_ff;
      chan_in       = chan_ff;
      res_color_in  = res_color_ff;
      res_status_in = res_status_ff;
      req_ready     = 1'b0;
      load_rsp      = 1'b0;
      blend_start   = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff[ADDR_W-1:0];
      mem_wr_data   = {pos_ff, color_ff};
      mem_rd_addr   = idx_ff[ADDR_W-1:0];
      case (state_ff)
         cgs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               mode_in  = req_ch.mode;
               pos_in   = req_pos_sat;
               color_in = {req_ch.in_alpha, req_ch.in_blue, req_ch.in_green, req_ch.in_red};
               idx_in   = '0;
               if (req_ch.mode == cgs_pkg::MODE_SAMPLE) begin
                  if (count_ff == '0) begin
                     res_color_in  = '0;
                     res_status_in = cgs_pkg::STATUS_NO_ENDS;
                     state_in      = cgs_pkg::ST_DONE;
                  end else begin
                     state_in = cgs_pkg::ST_END_RD;
                  end
               end else begin
                  state_in = cgs_pkg::ST_SCAN_RD;
               end
            end
         end
         cgs_pkg::ST_END_RD: begin
            mem_rd_addr = last_idx[ADDR_W-1:0];
            state_in    = cgs_pkg::ST_END_CHK;
         end
         cgs_pkg::ST_END_CHK: begin
            // sorted table: last stop must sit at 1.0
            if (rd_pos != cgs_pkg::POS_ONE) begin
               res_color_in  = '0;
               res_status_in = cgs_pkg::STATUS_NO_ENDS;
               state_in      = cgs_pkg::ST_DONE;
            end else begin
               state_in = cgs_pkg::ST_SCAN_RD;
            end
         end
         cgs_pkg::ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               // ran past every stop: append (writes only)
               res_color_in = '0;
               if (mode_ff == cgs_pkg::MODE_SAMPLE) begin
                  res_status_in = cgs_pkg::STATUS_NO_ENDS;
                  state_in      = cgs_pkg::ST_DONE;
               end else if (count_ff == MAX_CNT) begin
                  res_status_in = cgs_pkg::STATUS_FULL;
                  state_in      = cgs_pkg::ST_DONE;
               end else begin
                  top_in   = count_ff;
                  state_in = cgs_pkg::ST_INSERT;
               end
            end else begin
               state_in = cgs_pkg::ST_SCAN_CHK;
            end
         end
         cgs_pkg::ST_SCAN_CHK: begin
            if (mode_ff == cgs_pkg::MODE_SAMPLE && idx_ff == '0 && rd_pos != '0) begin
               res_color_in  = '0;
               res_status_in = cgs_pkg::STATUS_NO_ENDS;
               state_in      = cgs_pkg::ST_DONE;
            end else if (rd_pos < pos_ff) begin
               lo_pos_in   = rd_pos;
               lo_color_in = rd_color;
               idx_in      = idx_ff + CNT_W'(1);
               state_in    = cgs_pkg::ST_SCAN_RD;
            end else if (rd_pos == pos_ff) begin
               res_status_in = cgs_pkg::STATUS_OK;
               state_in      = cgs_pkg::ST_DONE;
               if (mode_ff == cgs_pkg::MODE_SAMPLE) begin
                  res_color_in = rd_color;
               end else begin
                  mem_wr_en    = 1'b1;
                  res_color_in = '0;
               end
            end else if (mode_ff == cgs_pkg::MODE_SAMPLE) begin
               hi_pos_in    = rd_pos;
               hi_color_in  = rd_color;
               chan_in      = '0;
               res_color_in = '0;
               state_in     = cgs_pkg::ST_BLEND_GO;
            end else if (count_ff == MAX_CNT) begin
               res_color_in  = '0;
               res_status_in = cgs_pkg::STATUS_FULL;
               state_in      = cgs_pkg::ST_DONE;
            end else begin
               top_in   = count_ff;
               state_in = cgs_pkg::ST_INSERT;
            end
         end
         cgs_pkg::ST_INSERT: begin
            if (top_ff == idx_ff) begin
               mem_wr_en     = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               res_color_in  = '0;
               res_status_in = cgs_pkg::STATUS_OK;
               state_in      = cgs_pkg::ST_DONE;
            end else begin
               mem_rd_addr = top_m1[ADDR_W-1:0];
               state_in    = cgs_pkg::ST_SHIFT_WR;
            end
         end
         cgs_pkg::ST_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = top_ff[ADDR_W-1:0];
            mem_wr_data = mem_rd_data;
            top_in      = top_m1;
            state_in    = cgs_pkg::ST_INSERT;
         end
         cgs_pkg::ST_BLEND_GO: begin
            blend_start = 1'b1;
            state_in    = cgs_pkg::ST_BLEND_WAIT;
         end
         cgs_pkg::ST_BLEND_WAIT: begin
            if (blend_done) begin
               res_color_in[{chan_ff, 3'b000} +: cgs_pkg::CHAN_W] = blend_q;
               if (chan_ff == 2'd3) begin
                  res_status_in = cgs_pkg::STATUS_OK;
                  state_in      = cgs_pkg::ST_DONE;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = cgs_pkg::ST_BLEND_GO;
               end
            end
         end
         cgs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = cgs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cgs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_color_ff  <= res_color_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_red   = rsp_color_ff[cgs_pkg::CHAN_W-1:0];
   assign rsp_ch.out_green = rsp_color_ff[2*cgs_pkg::CHAN_W-1:cgs_pkg::CHAN_W];
   assign rsp_ch.out_blue  = rsp_color_ff[3*cgs_pkg::CHAN_W-1:2*cgs_pkg::CHAN_W];
   assign rsp_ch.out_alpha = rsp_color_ff[4*cgs_pkg::CHAN_W-1:3*cgs_pkg::CHAN_W];
   assign rsp_ch.status    = rsp_status_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("stop count above table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)
                         || count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("stop count moved by more than one insert");

   a_blend_wait: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> state_ff == cgs_pkg::ST_BLEND_WAIT)
      else $error("blend result arrived outside the wait state");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == cgs_pkg::STATUS_FULL) |-> count_ff == MAX_CNT)
      else $error("full status with room left in the table");

   a_err_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != cgs_pkg::STATUS_OK) |-> rsp_color_ff == '0)
      else $error("error response carries a color");
`endif

endmodule

`default_nettype wire

// ===== sv/cgs_stop_mem.sv =====
// ----------------------------------------------------------------------------
// cgs_stop_mem
// Stop table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_stop_mem #(
   parameter int DEPTH  = cgs_pkg::MAX_STOPS_DEF,
   parameter int ADDR_W = 4,
   parameter int DATA_W = cgs_pkg::ENTRY_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/cgs_blend_unit.sv =====
// ----------------------------------------------------------------------------
// cgs_blend_unit
// One channel blend: (lo*(d-n) + hi*n) / d with a shared multiplier and
// a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_blend_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  cgs_pkg::blend_req_type     req,
   output logic                       done,
   output logic [cgs_pkg::CHAN_W-1:0] quot
);

   localparam int STEP_W = $clog2(cgs_pkg::QSTEPS);

   cgs_pkg::blend_state_type bstate_ff, bstate_in;
   logic [cgs_pkg::CHAN_W-1:0] lo_ff, lo_in;
   logic [cgs_pkg::CHAN_W-1:0] hi_ff, hi_in;
   logic [cgs_pkg::POS_W-1:0]  n_ff, n_in;
   logic [cgs_pkg::POS_W-1:0]  dn_ff, dn_in;
   logic [cgs_pkg::NUM_W-1:0]  div_ff, div_in;
   logic [cgs_pkg::NUM_W-1:0]  acc_ff, acc_in;
   logic [cgs_pkg::CHAN_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       done_ff, done_in;

   logic [cgs_pkg::CHAN_W-1:0] mul_x;
   logic [cgs_pkg::POS_W-1:0]  mul_y;
   logic [cgs_pkg::PROD_W-1:0] mul_p;
   logic [cgs_pkg::NUM_W:0]    diff;

   assign mul_x = (bstate_ff == cgs_pkg::BL_MUL_B) ? hi_ff : lo_ff;
   assign mul_y = (bstate_ff == cgs_pkg::BL_MUL_B) ? n_ff : dn_ff;
   assign mul_p = mul_x * mul_y;
   assign diff  = {1'b0, acc_ff} - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= cgs_pkg::BL_IDLE;
         done_ff   <= 1'b0;
      end else begin
         bstate_ff <= bstate_in;
         done_ff   <= done_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      n_ff    <= n_in;
      dn_ff   <= dn_in;
      div_ff  <= div_in;
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   always_comb begin
      bstate_in = bstate_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      n_in      = n_ff;
      dn_in     = dn_ff;
      div_in    = div_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      case (bstate_ff)
         cgs_pkg::BL_IDLE: begin
            if (start) begin
               lo_in     = req.lo_chan;
               hi_in     = req.hi_chan;
               n_in      = req.n;
               dn_in     = req.d - req.n;
               // divisor aligned to the top quotient bit
               div_in    = {req.d, (cgs_pkg::NUM_W - cgs_pkg::POS_W)'(0)};
               bstate_in = cgs_pkg::BL_MUL_A;
            end
         end
         cgs_pkg::BL_MUL_A: begin
            acc_in    = mul_p[cgs_pkg::NUM_W-1:0];
            bstate_in = cgs_pkg::BL_MUL_B;
         end
         cgs_pkg::BL_MUL_B: begin
            acc_in    = acc_ff + mul_p[cgs_pkg::NUM_W-1:0];
            q_in      = '0;
            step_in   = '0;
            bstate_in = cgs_pkg::BL_DIV;
         end
         cgs_pkg::BL_DIV: begin
            if (!diff[cgs_pkg::NUM_W]) begin
               acc_in = diff[cgs_pkg::NUM_W-1:0];
               q_in   = {q_ff[cgs_pkg::CHAN_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[cgs_pkg::CHAN_W-2:0], 1'b0};
            end
            div_in  = div_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(cgs_pkg::QSTEPS - 1)) begin
               done_in   = 1'b1;
               bstate_in = cgs_pkg::BL_IDLE;
            end
         end
         default: begin
            bstate_in = cgs_pkg::BL_IDLE;
         end
      endcase
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ===== test/color_gradient_sampler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// color_gradient_sampler_unit_tb
// Self-checking bench for the gradient stop table and sampler. A short table
// of directed requests (empty table, missing end stops, saturated positions,
// exact hits, blends, overwrites, table full) runs first. Random overwrites,
// dropped writes and samples follow under four idle/stall profiles. Each
// response is checked against a set value or a local stop table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_gradient_sampler_unit_tb;

   localparam int STOP_SLOTS       = cgs_pkg::MAX_STOPS_DEF;
   localparam int RANDOM_PER_PHASE = 275;
   localparam int IDLE_PLAN  [4]   = '{0, 79, 0, 18};
   localparam int STALL_PLAN [4]   = '{0, 0, 79, 18};
   localparam int POS_MAX          = 131071;

   typedef struct packed {
      logic [cgs_pkg::CHAN_W-1:0] alpha;
      logic [cgs_pkg::CHAN_W-1:0] blue;
      logic [cgs_pkg::CHAN_W-1:0] green;
      logic [cgs_pkg::CHAN_W-1:0] red;
   } rgba_type;

   typedef struct packed {
      rgba_type            color;
      cgs_pkg::status_type status;
   } shade_type;

   typedef struct {
      logic                      mode;
      logic [cgs_pkg::POS_W-1:0] position;
      rgba_type                  color;
      bit                        typed;
      shade_type                 want;
   } stim_row_type;

   localparam rgba_type BLACK_CLEAR  = '0;
   localparam rgba_type WHITE_OPAQUE = '1;

   logic clock;
   logic reset;

   cgs_req_if req_ch ();
   cgs_rsp_if rsp_ch ();

   color_gradient_sampler_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // model of the stop table
   logic [cgs_pkg::POS_W-1:0] tbl_pos   [STOP_SLOTS];
   rgba_type                  tbl_color [STOP_SLOTS];
   int                        tbl_count = 0;

   shade_type    colors_due [$];
   stim_row_type directed_rows [$];
   int           mismatches    = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout, %0d responses outstanding", $time, colors_due.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Applies one request to the table model and returns the expected response.
   function automatic shade_type gradient_eval(input logic mode,
                                               input logic [cgs_pkg::POS_W-1:0] position,
                                               input rgba_type color);
      shade_type                 res;
      logic [cgs_pkg::POS_W-1:0] p;
      logic [31:0]               lo_c, hi_c, blend;
      int unsigned               n, d, lo, hi, v;
      int                        i, j, k;
      res = '0;
      res.status = cgs_pkg::STATUS_OK;
      p = (position > cgs_pkg::POS_ONE) ? cgs_pkg::POS_ONE : position;
      i = 0;
      while (i < tbl_count && tbl_pos[i] < p) i++;

      if (mode == cgs_pkg::MODE_WRITE) begin
         if (i < tbl_count && tbl_pos[i] == p) begin
            tbl_color[i] = color;
         end else if (tbl_count >= STOP_SLOTS) begin
            res.status = cgs_pkg::STATUS_FULL;
         end else begin
            for (j = tbl_count; j > i; j--) begin
               tbl_pos[j]   = tbl_pos[j-1];
               tbl_color[j] = tbl_color[j-1];
            end
            tbl_pos[i]   = p;
            tbl_color[i] = color;
            tbl_count++;
         end
         return res;
      end

      if (tbl_count == 0 || tbl_pos[0] != '0 || tbl_pos[tbl_count-1] != cgs_pkg::POS_ONE) begin
         res.status = cgs_pkg::STATUS_NO_ENDS;
         return res;
      end
      if (tbl_pos[i] == p) begin
         res.color = tbl_color[i];
         return res;
      end

      // both ends exist, so 0 < i < tbl_count here
      n    = p - tbl_pos[i-1];
      d    = tbl_pos[i] - tbl_pos[i-1];
      lo_c = tbl_color[i-1];
      hi_c = tbl_color[i];
      for (k = 0; k < 4; k++) begin
         lo = lo_c[8*k +: 8];
         hi = hi_c[8*k +: 8];
         v  = (lo * (d - n) + hi * n) / d;
         if (v > 255) v = 255;
         blend[8*k +: 8] = v[7:0];
      end
      res.color = blend;
      return res;
   endfunction

   task automatic add_row(input logic mode, input int position, input rgba_type color,
                          input bit typed, input rgba_type want_color,
                          input cgs_pkg::status_type want_status);
      stim_row_type row;
      row.mode         = mode;
      row.position     = position[cgs_pkg::POS_W-1:0];
      row.color        = color;
      row.typed        = typed;
      row.want.color   = want_color;
      row.want.status  = want_status;
      directed_rows.push_back(row);
   endtask

   task automatic send_request(input stim_row_type row);
      shade_type model_out;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= row.mode;
      req_ch.position <= row.position;
      req_ch.in_red   <= row.color.red;
      req_ch.in_green <= row.color.green;
      req_ch.in_blue  <= row.color.blue;
      req_ch.in_alpha <= row.color.alpha;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      model_out = gradient_eval(row.mode, row.position, row.color);
      colors_due.push_back(row.typed ? row.want : model_out);
   endtask

   always @(posedge clock) begin : rsp_monitor
      shade_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (colors_due.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               mismatches++;
            end else begin
               want = colors_due.pop_front();
               if (rsp_ch.out_red !== want.color.red) begin
                  $display("%0t: red expected %0d got %0d", $time, want.color.red,
                           rsp_ch.out_red);
                  mismatches++;
               end
               if (rsp_ch.out_green !== want.color.green) begin
                  $display("%0t: green expected %0d got %0d", $time, want.color.green,
                           rsp_ch.out_green);
                  mismatches++;
               end
               if (rsp_ch.out_blue !== want.color.blue) begin
                  $display("%0t: blue expected %0d got %0d", $time, want.color.blue,
                           rsp_ch.out_blue);
                  mismatches++;
               end
               if (rsp_ch.out_alpha !== want.color.alpha) begin
                  $display("%0t: alpha expected %0d got %0d", $time, want.color.alpha,
                           rsp_ch.out_alpha);
                  mismatches++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status,
                           rsp_ch.status);
                  mismatches++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      stim_row_type              row;
      int                        fill_pos [14];
      int                        pick, phase, near;
      logic [cgs_pkg::POS_W-1:0] pos;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = cgs_pkg::MODE_WRITE;
      req_ch.position = '0;
      req_ch.in_red   = '0;
      req_ch.in_green = '0;
      req_ch.in_blue  = '0;
      req_ch.in_alpha = '0;

      // empty table, one end, both ends, saturated position, exact and blended hits
      add_row(cgs_pkg::MODE_SAMPLE, 32768, BLACK_CLEAR, 1, BLACK_CLEAR,
              cgs_pkg::STATUS_NO_ENDS);
      add_row(cgs_pkg::MODE_WRITE, 0, BLACK_CLEAR, 1, BLACK_CLEAR, cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, 0, WHITE_OPAQUE, 1, BLACK_CLEAR,
              cgs_pkg::STATUS_NO_ENDS);
      add_row(cgs_pkg::MODE_WRITE, POS_MAX, WHITE_OPAQUE, 1, BLACK_CLEAR,
              cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, 65536, BLACK_CLEAR, 1, WHITE_OPAQUE,
              cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, POS_MAX, BLACK_CLEAR, 1, WHITE_OPAQUE,
              cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, 32768, BLACK_CLEAR, 0, BLACK_CLEAR, cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, 65535, BLACK_CLEAR, 0, BLACK_CLEAR, cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_WRITE, 0, rgba_type'(32'h0180_00FF), 1, BLACK_CLEAR,
              cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, 20000, BLACK_CLEAR, 0, BLACK_CLEAR, cgs_pkg::STATUS_OK);
      // fill the table; order chosen so inserts land next to both end stops and in the middle
      fill_pos = '{60000, 10000, 40001, 40000, 40003, 2, 65535,
                   30000, 5, 50000, 20000, 1, 65534, 45000};
      foreach (fill_pos[f])
         add_row(cgs_pkg::MODE_WRITE, fill_pos[f], rgba_type'($urandom), 1, BLACK_CLEAR,
                 cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_WRITE, 33333, WHITE_OPAQUE, 1, BLACK_CLEAR,
              cgs_pkg::STATUS_FULL);
      add_row(cgs_pkg::MODE_WRITE, 40000, rgba_type'($urandom), 1, BLACK_CLEAR,
              cgs_pkg::STATUS_OK);
      add_row(cgs_pkg::MODE_SAMPLE, 40002, BLACK_CLEAR, 0, BLACK_CLEAR, cgs_pkg::STATUS_OK);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_request(directed_rows[r]);

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = IDLE_PLAN[phase];
         rsp_stall_pct = STALL_PLAN[phase];
         repeat (RANDOM_PER_PHASE) begin
            pick      = $urandom_range(0, 99);
            row.typed = 1'b0;
            row.want  = '0;
            row.color = rgba_type'($urandom);
            if (pick < 35) begin
               // recolor an existing stop
               row.mode = cgs_pkg::MODE_WRITE;
               pos      = tbl_pos[$urandom_range(0, tbl_count - 1)];
            end else if (pick < 42) begin
               row.mode = cgs_pkg::MODE_WRITE;
               pos      = cgs_pkg::POS_W'($urandom_range(0, POS_MAX));
            end else if (pick < 62) begin
               row.mode = cgs_pkg::MODE_SAMPLE;
               pos      = cgs_pkg::POS_W'($urandom_range(0, POS_MAX));
            end else if (pick < 82) begin
               // just around a stop, where spans are narrow
               row.mode = cgs_pkg::MODE_SAMPLE;
               near     = int'(tbl_pos[$urandom_range(0, tbl_count - 1)])
                          + $urandom_range(0, 6) - 3;
               if (near < 0) near = 0;
               pos      = cgs_pkg::POS_W'(near);
            end else begin
               row.mode = cgs_pkg::MODE_SAMPLE;
               pos      = tbl_pos[$urandom_range(0, tbl_count - 1)];
            end
            row.position = pos;
            send_request(row);
         end
         // hold off until the block has drained
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (colors_due.size() != 0);
      end

      rsp_stall_pct = 0;
      repeat (200) @(posedge clock);
      if (mismatches == 0 && colors_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
